FILE: rtl/sarsa_q_table_learner_defines.svh
// Assertion macros shared by the SARSA Q table learner RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef SARSA_Q_TABLE_LEARNER_DEFINES_SVH
`define SARSA_Q_TABLE_LEARNER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SQTL_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sqtl: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SQTL_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sqtl: next-cycle check failed");

`endif

FILE: rtl/sqtl_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// SARSA Q table learner. No dependencies.
package sqtl_pkg;

	localparam int MAX_STATES  = 1024;
	localparam int MAX_ACTIONS = 16;
	localparam int VALUE_W     = 32;
	localparam int STATE_W     = $clog2(MAX_STATES);
	localparam int ACTION_W    = $clog2(MAX_ACTIONS);
	localparam int ADDR_W      = STATE_W + ACTION_W;
	localparam int DEPTH       = MAX_STATES * MAX_ACTIONS;
	localparam int RAND_W      = 16;
	localparam int REM_CNT_W   = $clog2(RAND_W);
	localparam int CMD_W       = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int GAIN_W      = 17;
	localparam int NACT_W      = ACTION_W + 1;
	localparam int NSTATE_W    = STATE_W + 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DISCOUNT    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPLORE_PER = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIONS     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STATES      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LEARN_FRZ   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPLORE_FRZ = 3'd6;

	// register reset values
	localparam logic [GAIN_W-1:0]   Q16_ONE          = 17'h10000;
	localparam logic [GAIN_W-1:0]   STEP_SIZE_RST    = 17'd6554;
	localparam logic [GAIN_W-1:0]   DISCOUNT_RST     = Q16_ONE;
	localparam logic [RAND_W-1:0]   EXPLORE_PER_RST  = 16'd10;
	localparam logic [NACT_W-1:0]   ACTIONS_RST      = NACT_W'(MAX_ACTIONS);
	localparam logic [NSTATE_W-1:0] STATES_RST       = NSTATE_W'(MAX_STATES);

	// where a decoded item goes
	typedef enum logic [1:0] {
		ROUTE_FINISH,
		ROUTE_CHOOSE,
		ROUTE_END
	} route_t;

	typedef struct packed {
		logic clear;
		logic scan_start;
		logic scan_run;
		logic choose;
		logic rd_next;
		logic rd_prev;
		logic take_prev;
		logic mul_g;
		logic calc_t;
		logic calc_d;
		logic mul_a;
		logic calc_v;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic   clear_last;
		route_t route;
		logic   step_open;
		logic   scan_done;
		logic   rem_done;
		logic   out_free;
	} dp_status_t;

endpackage

FILE: rtl/sqtl_rem.sv
// Iterative remainder unit: one restoring step per cycle over the dividend bits.
// Depends on sqtl_pkg.
module sqtl_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sqtl_pkg::RAND_W-1:0]  dividend,
	input  logic [sqtl_pkg::RAND_W-1:0]  divisor,
	output logic                         done,
	output logic [sqtl_pkg::RAND_W-1:0]  rem
);

	logic                            busy_q;
	logic [sqtl_pkg::REM_CNT_W-1:0]  cnt_q;
	logic [sqtl_pkg::RAND_W-1:0]     rem_q;
	logic [sqtl_pkg::RAND_W-1:0]     shift_q;
	logic [sqtl_pkg::RAND_W:0]       trial;
	logic [sqtl_pkg::RAND_W:0]       trial_next;

	always_comb begin
		trial      = {rem_q, shift_q[sqtl_pkg::RAND_W-1]};
		trial_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == sqtl_pkg::REM_CNT_W'(sqtl_pkg::RAND_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (busy_q) begin
			rem_q   <= trial_next[sqtl_pkg::RAND_W-1:0];
			shift_q <= {shift_q[sqtl_pkg::RAND_W-2:0], 1'b0};
		end
	end

	assign done = !busy_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/sqtl_ctrl.sv
// Controller state machine: sequences the clearing pass, the action scan and the
// read-modify-write update. Depends on sqtl_pkg.
module sqtl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sqtl_pkg::dp_status_t   stat,
	output sqtl_pkg::ctrl_cmd_t    ctl
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_CHOOSE,
		ST_RD_NEXT,
		ST_RD_PREV,
		ST_WAIT_PREV,
		ST_MUL_G,
		ST_CALC_T,
		ST_CALC_D,
		ST_MUL_A,
		ST_CALC_V,
		ST_FINISH
	} state_t;

	state_t              state_q;
	state_t              state_d;
	sqtl_pkg::ctrl_cmd_t ctl_q;
	logic                in_ready_q;

	function automatic sqtl_pkg::ctrl_cmd_t cmd_for(state_t st);
		sqtl_pkg::ctrl_cmd_t c;
		c = '0;
		case (st)
			ST_CLEAR:     c.clear      = 1'b1;
			ST_DECODE:    c.scan_start = 1'b1;
			ST_SCAN:      c.scan_run   = 1'b1;
			ST_CHOOSE:    c.choose     = 1'b1;
			ST_RD_NEXT:   c.rd_next    = 1'b1;
			ST_RD_PREV:   c.rd_prev    = 1'b1;
			ST_WAIT_PREV: c.take_prev  = 1'b1;
			ST_MUL_G:     c.mul_g      = 1'b1;
			ST_CALC_T:    c.calc_t     = 1'b1;
			ST_CALC_D:    c.calc_d     = 1'b1;
			ST_MUL_A:     c.mul_a      = 1'b1;
			ST_CALC_V:    c.calc_v     = 1'b1;
			ST_FINISH:    c.finish     = 1'b1;
			default:      c            = '0;
		endcase
		return c;
	endfunction

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (stat.route)
					sqtl_pkg::ROUTE_CHOOSE: state_d = ST_SCAN;
					sqtl_pkg::ROUTE_END:    state_d = ST_RD_PREV;
					default:                state_d = ST_FINISH;
				endcase
			end
			ST_SCAN: begin
				if (stat.scan_done && stat.rem_done) state_d = ST_CHOOSE;
			end
			ST_CHOOSE: begin
				state_d = stat.step_open ? ST_RD_NEXT : ST_FINISH;
			end
			ST_RD_NEXT:   state_d = ST_RD_PREV;
			ST_RD_PREV:   state_d = ST_WAIT_PREV;
			ST_WAIT_PREV: begin
				// an end has no next-state term to discount
				state_d = (stat.route == sqtl_pkg::ROUTE_END) ? ST_CALC_T : ST_MUL_G;
			end
			ST_MUL_G:     state_d = ST_CALC_T;
			ST_CALC_T:    state_d = ST_CALC_D;
			ST_CALC_D:    state_d = ST_MUL_A;
			ST_MUL_A:     state_d = ST_CALC_V;
			ST_CALC_V:    state_d = ST_FINISH;
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			ctl_q      <= '{clear: 1'b1, default: 1'b0};
			in_ready_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ctl_q      <= cmd_for(state_d);
			in_ready_q <= (state_d == ST_IDLE);
		end
	end

	assign ctl      = ctl_q;
	assign in_ready = in_ready_q;

endmodule

FILE: rtl/sqtl_dp.sv
// Datapath: registers, Q table memory, action scan, remainder unit, Q16.16
// update arithmetic and the output register. Depends on sqtl_pkg and sqtl_rem.
module sqtl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [sqtl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [sqtl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [sqtl_pkg::CMD_W-1:0]           cmd,
	input  logic [sqtl_pkg::STATE_W-1:0]         obs_state,
	input  logic signed [sqtl_pkg::VALUE_W-1:0]  reward,
	input  logic [sqtl_pkg::RAND_W-1:0]          rand_gate,
	input  logic [sqtl_pkg::RAND_W-1:0]          rand_pick,
	input  sqtl_pkg::ctrl_cmd_t                  ctl,
	output sqtl_pkg::dp_status_t                 stat,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [sqtl_pkg::ACTION_W-1:0]        action,
	output logic                                 action_valid,
	output logic                                 explored,
	output logic                                 value_written,
	output logic signed [sqtl_pkg::VALUE_W-1:0]  new_value,
	output logic                                 bad_state
);

	localparam int VW = sqtl_pkg::VALUE_W;
	localparam int AW = sqtl_pkg::ACTION_W;
	localparam int SW = sqtl_pkg::STATE_W;
	localparam int PW = VW + sqtl_pkg::GAIN_W + 1;

	// clamp a value two bits wider than a Q value into the Q value range
	function automatic logic signed [VW-1:0] sat_v(logic signed [VW+1:0] x);
		logic signed [VW-1:0] r;
		if (x[VW+1:VW-1] == 3'b000 || x[VW+1:VW-1] == 3'b111) begin
			r = x[VW-1:0];
		end else if (x[VW+1]) begin
			r = {1'b1, {(VW-1){1'b0}}};
		end else begin
			r = {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [sqtl_pkg::GAIN_W-1:0] clamp_gain(
		logic [sqtl_pkg::CFG_DATA_W-1:0] v);
		logic [sqtl_pkg::GAIN_W-1:0] g;
		g = v[sqtl_pkg::GAIN_W-1:0];
		return (g > sqtl_pkg::Q16_ONE) ? sqtl_pkg::Q16_ONE : g;
	endfunction

	// configuration registers
	logic [sqtl_pkg::GAIN_W-1:0]   step_size_q;
	logic [sqtl_pkg::GAIN_W-1:0]   discount_q;
	logic [sqtl_pkg::RAND_W-1:0]   explore_per_q;
	logic [sqtl_pkg::NACT_W-1:0]   actions_q;
	logic [sqtl_pkg::NSTATE_W-1:0] states_q;
	logic                          learn_frz_q;
	logic                          explore_frz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q   <= sqtl_pkg::STEP_SIZE_RST;
			discount_q    <= sqtl_pkg::DISCOUNT_RST;
			explore_per_q <= sqtl_pkg::EXPLORE_PER_RST;
			actions_q     <= sqtl_pkg::ACTIONS_RST;
			states_q      <= sqtl_pkg::STATES_RST;
			learn_frz_q   <= 1'b0;
			explore_frz_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				sqtl_pkg::REG_STEP_SIZE:   step_size_q   <= clamp_gain(cfg_data);
				sqtl_pkg::REG_DISCOUNT:    discount_q    <= clamp_gain(cfg_data);
				sqtl_pkg::REG_EXPLORE_PER: explore_per_q <= cfg_data[sqtl_pkg::RAND_W-1:0];
				sqtl_pkg::REG_ACTIONS:     actions_q     <= cfg_data[sqtl_pkg::NACT_W-1:0];
				sqtl_pkg::REG_STATES:      states_q      <= cfg_data[sqtl_pkg::NSTATE_W-1:0];
				sqtl_pkg::REG_LEARN_FRZ:   learn_frz_q   <= cfg_data[0];
				sqtl_pkg::REG_EXPLORE_FRZ: explore_frz_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [sqtl_pkg::NACT_W-1:0]   n_eff;
	logic [sqtl_pkg::NSTATE_W-1:0] s_eff;

	always_comb begin
		if (actions_q == '0) begin
			n_eff = sqtl_pkg::NACT_W'(1);
		end else if (actions_q > sqtl_pkg::NACT_W'(sqtl_pkg::MAX_ACTIONS)) begin
			n_eff = sqtl_pkg::NACT_W'(sqtl_pkg::MAX_ACTIONS);
		end else begin
			n_eff = actions_q;
		end
		if (states_q == '0) begin
			s_eff = sqtl_pkg::NSTATE_W'(1);
		end else if (states_q > sqtl_pkg::NSTATE_W'(sqtl_pkg::MAX_STATES)) begin
			s_eff = sqtl_pkg::NSTATE_W'(sqtl_pkg::MAX_STATES);
		end else begin
			s_eff = states_q;
		end
	end

	// latched transaction
	logic                        load;
	logic [sqtl_pkg::CMD_W-1:0]  cmd_q;
	logic [SW-1:0]               s_q;
	logic signed [VW-1:0]        reward_q;
	logic [sqtl_pkg::RAND_W-1:0] gate_q;
	logic [sqtl_pkg::RAND_W-1:0] pick_q;

	assign load = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q    <= cmd;
			s_q      <= obs_state;
			reward_q <= reward;
			gate_q   <= rand_gate;
			pick_q   <= rand_pick;
		end
	end

	// episode state
	logic          episode_open_q;
	logic [SW-1:0] prev_s_q;
	logic [AW-1:0] prev_a_q;

	// decode
	logic             choose_cmd;
	logic             bad;
	sqtl_pkg::route_t route;

	always_comb begin
		choose_cmd = (cmd_q == sqtl_pkg::CMD_START) || (cmd_q == sqtl_pkg::CMD_STEP);
		bad        = choose_cmd && ({1'b0, s_q} >= s_eff);
		route      = sqtl_pkg::ROUTE_FINISH;
		if (choose_cmd && !bad) begin
			route = sqtl_pkg::ROUTE_CHOOSE;
		end else if (cmd_q == sqtl_pkg::CMD_END && episode_open_q) begin
			route = sqtl_pkg::ROUTE_END;
		end
	end

	// Q table
	logic signed [VW-1:0]          q_mem [sqtl_pkg::DEPTH];
	logic signed [VW-1:0]          rd_data_q;
	logic [sqtl_pkg::ADDR_W-1:0]   rd_addr;
	logic [sqtl_pkg::ADDR_W-1:0]   clr_cnt_q;
	logic                          mem_we;
	logic [sqtl_pkg::ADDR_W-1:0]   mem_waddr;
	logic signed [VW-1:0]          mem_wdata;
	logic signed [VW-1:0]          v_c;

	// action scan
	logic [sqtl_pkg::NACT_W-1:0] scan_cnt_q;
	logic                        rd_hit_s1;
	logic [AW-1:0]               rd_tag_s1;
	logic                        scan_issue;
	logic signed [VW-1:0]        best_q;
	logic [AW-1:0]               best_a_q;
	logic [AW-1:0]               act_q;

	assign scan_issue = ctl.scan_run && (scan_cnt_q < n_eff);

	always_comb begin
		if (scan_issue) begin
			rd_addr = {s_q, scan_cnt_q[AW-1:0]};
		end else if (ctl.rd_next) begin
			rd_addr = {s_q, act_q};
		end else begin
			rd_addr = {prev_s_q, prev_a_q};
		end
		mem_we    = ctl.clear || (ctl.calc_v && !learn_frz_q);
		mem_waddr = ctl.clear ? clr_cnt_q : {prev_s_q, prev_a_q};
		mem_wdata = ctl.clear ? '0 : v_c;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			q_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= q_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_hit_s1  <= 1'b0;
			rd_tag_s1  <= '0;
		end else if (ctl.scan_start) begin
			scan_cnt_q <= '0;
			rd_hit_s1  <= 1'b0;
		end else begin
			rd_hit_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
				rd_tag_s1  <= scan_cnt_q[AW-1:0];
			end
		end
	end

	// keep the lowest-numbered action on ties
	always_ff @(posedge clk) begin
		if (rd_hit_s1 && (rd_tag_s1 == '0 || rd_data_q > best_q)) begin
			best_q   <= rd_data_q;
			best_a_q <= rd_tag_s1;
		end
	end

	// exploration decision
	logic                        rem_done;
	logic [sqtl_pkg::RAND_W-1:0] rem;
	logic                        explore;
	logic [sqtl_pkg::RAND_W+sqtl_pkg::NACT_W-1:0] pick_prod;

	sqtl_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.scan_start),
		.dividend (gate_q),
		.divisor  (explore_per_q),
		.done     (rem_done),
		.rem      (rem)
	);

	always_comb begin
		explore   = !explore_frz_q && (explore_per_q != '0)
		            && (rem == sqtl_pkg::RAND_W'(1));
		pick_prod = {{sqtl_pkg::NACT_W{1'b0}}, pick_q}
		            * {{sqtl_pkg::RAND_W{1'b0}}, n_eff};
	end

	// update arithmetic
	logic signed [VW-1:0]        qn_q;
	logic signed [VW-1:0]        q_q;
	logic signed [VW-1:0]        t_q;
	logic signed [VW-1:0]        d_q;
	logic signed [PW-1:0]        prod_q;
	logic signed [VW-1:0]        mul_x;
	logic [sqtl_pkg::GAIN_W-1:0] mul_g;
	logic signed [VW:0]          u;
	logic signed [VW+1:0]        t_sum;
	logic signed [VW+1:0]        d_diff;
	logic signed [VW+1:0]        v_sum;

	always_comb begin
		mul_x  = ctl.mul_g ? qn_q : d_q;
		mul_g  = ctl.mul_g ? discount_q : step_size_q;
		// floor(x * g / 2^16) is the product shifted arithmetically
		u      = prod_q[VW+16:16];
		t_sum  = {{2{reward_q[VW-1]}}, reward_q} + {u[VW], u};
		d_diff = {{2{t_q[VW-1]}}, t_q} - {{2{q_q[VW-1]}}, q_q};
		v_sum  = {{2{q_q[VW-1]}}, q_q} + {u[VW], u};
		v_c    = sat_v(v_sum);
	end

	logic                 explored_q;
	logic                 written_q;
	logic signed [VW-1:0] nv_q;

	always_ff @(posedge clk) begin
		if (load) begin
			act_q      <= '0;
			explored_q <= 1'b0;
			written_q  <= 1'b0;
			nv_q       <= '0;
		end
		if (ctl.choose) begin
			act_q      <= explore ? pick_prod[sqtl_pkg::RAND_W+AW-1:sqtl_pkg::RAND_W]
			                      : best_a_q;
			explored_q <= explore;
		end
		if (ctl.rd_prev) begin
			qn_q <= rd_data_q;
		end
		if (ctl.take_prev) begin
			q_q <= rd_data_q;
		end
		if (ctl.mul_g || ctl.mul_a) begin
			prod_q <= mul_x * $signed({1'b0, mul_g});
		end
		if (ctl.calc_t) begin
			t_q <= (route == sqtl_pkg::ROUTE_END) ? reward_q : sat_v(t_sum);
		end
		if (ctl.calc_d) begin
			d_q <= sat_v(d_diff);
		end
		if (ctl.calc_v && !learn_frz_q) begin
			written_q <= 1'b1;
			nv_q      <= v_c;
		end
	end

	// output register and episode bookkeeping
	logic out_valid_q;
	logic out_free;
	logic finish_go;

	assign out_free  = !out_valid_q || out_ready;
	assign finish_go = ctl.finish && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			episode_open_q <= 1'b0;
			prev_s_q       <= '0;
			prev_a_q       <= '0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (finish_go && route == sqtl_pkg::ROUTE_CHOOSE) begin
				prev_s_q       <= s_q;
				prev_a_q       <= act_q;
				episode_open_q <= 1'b1;
			end else if (finish_go && route == sqtl_pkg::ROUTE_END) begin
				prev_s_q       <= '0;
				prev_a_q       <= '0;
				episode_open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			action        <= act_q;
			action_valid  <= (route == sqtl_pkg::ROUTE_CHOOSE);
			explored      <= explored_q;
			value_written <= written_q;
			new_value     <= nv_q;
			bad_state     <= bad;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.clear_last = (clr_cnt_q == '1);
		stat.route      = route;
		stat.step_open  = (cmd_q == sqtl_pkg::CMD_STEP) && episode_open_q;
		stat.scan_done  = (scan_cnt_q == n_eff) && !rd_hit_s1;
		stat.rem_done   = rem_done;
		stat.out_free   = out_free;
	end

endmodule

FILE: rtl/sarsa_q_table_learner.sv
// Tabular SARSA learner with epsilon-greedy action choice over a 1024 x 16 Q table
// of signed Q16.16 values. After reset a clearing pass writes zero to all 16384
// table entries, one per cycle, and in_ready stays low until it ends;
// configuration writes are taken throughout. One transaction is in work at a time.
// A start, or a step with no open episode, runs the explore test, a remainder
// unit that takes one bit a cycle, alongside the greedy scan, which reads one
// action's Q value per cycle from the single-read-port table, and then chooses
// an action. A step that updates goes on to the two table reads, two multiplies
// and the saturating adds; an end reads only the previous entry and skips the
// discount multiply, and a bad state, an unused command or an end with no open
// episode goes straight from decode to the result. The output register lets the
// next transaction be accepted while a result waits.
// Depends on sqtl_pkg, sqtl_ctrl, sqtl_dp, sqtl_rem and the defines header.
`include "sarsa_q_table_learner_defines.svh"

module sarsa_q_table_learner (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [sqtl_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [sqtl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sqtl_pkg::CMD_W-1:0]           cmd,
	input  logic [sqtl_pkg::STATE_W-1:0]         obs_state,
	input  logic signed [sqtl_pkg::VALUE_W-1:0]  reward,
	input  logic [sqtl_pkg::RAND_W-1:0]          rand_gate,
	input  logic [sqtl_pkg::RAND_W-1:0]          rand_pick,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sqtl_pkg::ACTION_W-1:0]        action,
	output logic                                 action_valid,
	output logic                                 explored,
	output logic                                 value_written,
	output logic signed [sqtl_pkg::VALUE_W-1:0]  new_value,
	output logic                                 bad_state
);

	sqtl_pkg::ctrl_cmd_t  ctl;
	sqtl_pkg::dp_status_t stat;

	sqtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	sqtl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.obs_state     (obs_state),
		.reward        (reward),
		.rand_gate     (rand_gate),
		.rand_pick     (rand_pick),
		.ctl           (ctl),
		.stat          (stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.action        (action),
		.action_valid  (action_valid),
		.explored      (explored),
		.value_written (value_written),
		.new_value     (new_value),
		.bad_state     (bad_state)
	);

	// one transaction in work at a time
	`SQTL_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready)
	// never overwrite a result that is still waiting
	`SQTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_value))
	// a flagged state carries no action and no update
	`SQTL_ASSERT_NOW(a_bad_quiet, out_valid && bad_state, !action_valid && !value_written)
	// no update means a zero value field
	`SQTL_ASSERT_NOW(a_nv_zero, out_valid && !value_written, new_value == '0)

endmodule
